/* hdl/lsp_pkg.sv */
// shared types, widths and constants for the letterbox scaler and pixel packer
package lsp_pkg;

	localparam int unsigned SCALE_FRAC_BITS      = 16;
	localparam int unsigned DEF_MAX_IMAGE_PIXELS = 65536;

	localparam int unsigned COORD_W    = 12;
	localparam int unsigned DIM_W      = 13;
	localparam int unsigned SCALE_W    = 24;
	localparam int unsigned CH_W       = 8;
	localparam int unsigned RGB_W      = 3 * CH_W;
	localparam int unsigned PIX_W      = 32;
	localparam int unsigned OPT_W      = 5;
	localparam int unsigned GRP_W      = 10;
	localparam int unsigned LAYOUT_W   = 3 * GRP_W;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 30;

	// fit ratio quotient, offsets and per pixel divider widths
	localparam int unsigned QW       = DIM_W + SCALE_FRAC_BITS;
	localparam int unsigned SAT_W    = (QW > SCALE_W) ? QW : SCALE_W;
	localparam int unsigned CNT_W    = $clog2(QW);
	localparam int unsigned PROD_W   = DIM_W + SCALE_W;
	localparam int unsigned SCALED_W = PROD_W - SCALE_FRAC_BITS;
	localparam int unsigned OFS_W    = SCALED_W + 2;
	localparam int unsigned DW       = OFS_W + 1;
	localparam int unsigned DD_W     = DW + SCALE_FRAC_BITS;
	localparam int unsigned QB       = DIM_W;
	localparam int unsigned RW       = SCALE_W + QB;
	localparam int unsigned IDX_W    = 2 * DIM_W;

	localparam logic [SCALE_W-1:0] SCALE_MAX = '1;

	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_RENDER = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_W = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_H = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_W  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_H  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_OPTIONS  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_LAYOUT   = 3'd6;

	localparam int unsigned OPT_WHITE = 0;
	// left or top, right or bottom
	localparam logic [1:0] ALIGN_NEAR = 2'd1;
	localparam logic [1:0] ALIGN_FAR  = 2'd2;

	typedef struct packed {
		logic               operation;
		logic [COORD_W-1:0] x_coord;
		logic [COORD_W-1:0] y_coord;
		logic [CH_W-1:0]    red;
		logic [CH_W-1:0]    green;
		logic [CH_W-1:0]    blue;
	} in_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_value;
		logic             covered;
	} out_t;

	typedef struct packed {
		logic                busy;
		logic [DIM_W-1:0]    screen_w;
		logic [DIM_W-1:0]    screen_h;
		logic [DIM_W-1:0]    image_w;
		logic [DIM_W-1:0]    image_h;
		logic [SCALE_W-1:0]  user_scale;
		logic [SCALE_W-1:0]  scale;
		logic [OFS_W-1:0]    h_off;
		logic [OFS_W-1:0]    v_off;
		logic [OPT_W-1:0]    options;
		logic [LAYOUT_W-1:0] layout;
	} cfg_t;

	typedef struct packed {
		in_t           item;
		logic          in_scr;
		logic          neg_x;
		logic          neg_y;
		logic          ovf_x;
		logic          ovf_y;
		logic [QB-1:0] q_x;
		logic [QB-1:0] q_y;
	} map_res_t;

	// c*(2^w-1)/255 = c*k[w] + c*(2^(w%8)-1)/255
	typedef logic [31:0][SCALE_W-1:0] chan_k_t;

	function automatic chan_k_t build_chan_k();
		chan_k_t t;
		for (int w = 0; w < 32; w++) begin
			t[w] = SCALE_W'(((64'd1 << w) - (64'd1 << (w % 8))) / 64'd255);
		end
		return t;
	endfunction

	localparam chan_k_t CHAN_K = build_chan_k();

endpackage

/* hdl/lsp_cfg.sv */
// configuration registers and serial derivation of scale and alignment offsets
module lsp_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [lsp_pkg::CFG_IDX_W-1:0]  index,
	input  logic [lsp_pkg::CFG_DATA_W-1:0] data,
	output lsp_pkg::cfg_t                  cfg
);
	import lsp_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_START = 6'b000010,
		ST_DIV   = 6'b000100,
		ST_SCALE = 6'b001000,
		ST_PROD  = 6'b010000,
		ST_OFS   = 6'b100000
	} state_t;

	state_t state_q;

	logic [DIM_W-1:0]    screen_w_q, screen_h_q, image_w_q, image_h_q;
	logic [SCALE_W-1:0]  user_scale_q;
	logic [OPT_W-1:0]    options_q;
	logic [LAYOUT_W-1:0] layout_q;

	logic [QW-1:0]      dvd_h_q, dvd_v_q;
	logic [DIM_W-1:0]   rem_h_q, rem_v_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [SCALE_W-1:0] scale_q;
	logic [PROD_W-1:0]  prod_h_q, prod_v_q;
	logic [OFS_W-1:0]   h_off_q, v_off_q;

	logic [DIM_W:0]     trial_h, trial_v;
	logic               ge_h, ge_v;
	logic [DIM_W-1:0]   rem_h_nx, rem_v_nx;
	logic [SCALE_W-1:0] fit_h, fit_v, fit, eff;
	logic [OFS_W-1:0]   diff_h, diff_v;

	function automatic logic [OFS_W-1:0] align(logic [OFS_W-1:0] diff, logic [1:0] mode);
		logic [OFS_W-1:0] rnd;
		rnd = diff + OFS_W'(diff[OFS_W-1]);
		case (mode)
			ALIGN_NEAR: return '0;
			ALIGN_FAR:  return diff;
			default:    return {rnd[OFS_W-1], rnd[OFS_W-1:1]};
		endcase
	endfunction

	// one quotient bit per cycle for both fit ratios
	always_comb begin
		trial_h  = {rem_h_q, dvd_h_q[QW-1]};
		trial_v  = {rem_v_q, dvd_v_q[QW-1]};
		ge_h     = trial_h >= {1'b0, image_w_q};
		ge_v     = trial_v >= {1'b0, image_h_q};
		rem_h_nx = ge_h ? DIM_W'(trial_h - {1'b0, image_w_q}) : trial_h[DIM_W-1:0];
		rem_v_nx = ge_v ? DIM_W'(trial_v - {1'b0, image_h_q}) : trial_v[DIM_W-1:0];
		fit_h    = (SAT_W'(dvd_h_q) > SAT_W'(SCALE_MAX)) ? SCALE_MAX : SCALE_W'(dvd_h_q);
		fit_v    = (SAT_W'(dvd_v_q) > SAT_W'(SCALE_MAX)) ? SCALE_MAX : SCALE_W'(dvd_v_q);
		fit      = (fit_h < fit_v) ? fit_h : fit_v;
		eff      = (user_scale_q != '0) ? user_scale_q : fit;
		diff_h   = OFS_W'(screen_w_q) - OFS_W'(prod_h_q[PROD_W-1:SCALE_FRAC_BITS]);
		diff_v   = OFS_W'(screen_h_q) - OFS_W'(prod_v_q[PROD_W-1:SCALE_FRAC_BITS]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_w_q   <= DIM_W'(1920);
			screen_h_q   <= DIM_W'(1080);
			image_w_q    <= DIM_W'(256);
			image_h_q    <= DIM_W'(256);
			user_scale_q <= '0;
			options_q    <= '0;
			layout_q     <= '0;
			state_q      <= ST_START;
		end else if (wr_en && index <= REG_LAYOUT) begin
			case (index)
				REG_SCREEN_W: screen_w_q   <= data[DIM_W-1:0];
				REG_SCREEN_H: screen_h_q   <= data[DIM_W-1:0];
				REG_IMAGE_W:  image_w_q    <= data[DIM_W-1:0];
				REG_IMAGE_H:  image_h_q    <= data[DIM_W-1:0];
				REG_SCALE:    user_scale_q <= data[SCALE_W-1:0];
				REG_OPTIONS:  options_q    <= data[OPT_W-1:0];
				default:      layout_q     <= data[LAYOUT_W-1:0];
			endcase
			state_q <= ST_START;
		end else begin
			case (state_q)
				ST_START: state_q <= ST_DIV;
				ST_DIV:   if (cnt_q == CNT_W'(QW - 1)) state_q <= ST_SCALE;
				ST_SCALE: state_q <= ST_PROD;
				ST_PROD:  state_q <= ST_OFS;
				ST_OFS:   state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_START: begin
				dvd_h_q <= {screen_w_q, {SCALE_FRAC_BITS{1'b0}}};
				dvd_v_q <= {screen_h_q, {SCALE_FRAC_BITS{1'b0}}};
				rem_h_q <= '0;
				rem_v_q <= '0;
				cnt_q   <= '0;
			end
			ST_DIV: begin
				dvd_h_q <= {dvd_h_q[QW-2:0], ge_h};
				dvd_v_q <= {dvd_v_q[QW-2:0], ge_v};
				rem_h_q <= rem_h_nx;
				rem_v_q <= rem_v_nx;
				cnt_q   <= cnt_q + 1'b1;
			end
			ST_SCALE: scale_q <= eff;
			ST_PROD: begin
				prod_h_q <= PROD_W'(image_w_q) * PROD_W'(scale_q);
				prod_v_q <= PROD_W'(image_h_q) * PROD_W'(scale_q);
			end
			ST_OFS: begin
				h_off_q <= align(diff_h, options_q[2:1]);
				v_off_q <= align(diff_v, options_q[4:3]);
			end
			default: ;
		endcase
	end

	always_comb begin
		cfg.busy       = state_q != ST_IDLE;
		cfg.screen_w   = screen_w_q;
		cfg.screen_h   = screen_h_q;
		cfg.image_w    = image_w_q;
		cfg.image_h    = image_h_q;
		cfg.user_scale = user_scale_q;
		cfg.scale      = scale_q;
		cfg.h_off      = h_off_q;
		cfg.v_off      = v_off_q;
		cfg.options    = options_q;
		cfg.layout     = layout_q;
	end

endmodule

/* hdl/lsp_map.sv */
// screen to source coordinate mapping: offset subtract, then bit per stage division by the scale
module lsp_map (
	input  logic              clk,
	input  logic              arst_n,
	input  lsp_pkg::cfg_t     cfg,
	input  logic              in_valid,
	output logic              in_ready,
	input  lsp_pkg::in_t      in_data,
	output logic              res_valid,
	input  logic              res_ready,
	output lsp_pkg::map_res_t res
);
	import lsp_pkg::*;

	typedef struct packed {
		in_t           item;
		logic          in_scr;
		logic          neg_x;
		logic          neg_y;
		logic          ovf_x;
		logic          ovf_y;
		logic [RW-1:0] rem_x;
		logic [RW-1:0] rem_y;
		logic [QB-1:0] q_x;
		logic [QB-1:0] q_y;
	} map_pipe_t;

	logic          v_s1;
	in_t           item_s1;
	logic          in_scr_s1, neg_x_s1, neg_y_s1;
	logic [DW-1:0] mag_x_s1, mag_y_s1;

	// entry k holds the item after k quotient bits
	logic      vld_s2 [QB+1];
	map_pipe_t dp_s2  [QB+1];
	logic      adv_s2 [QB+1];
	logic      adv_s1;

	logic [DW-1:0]   dx, dy;
	logic [DD_W-1:0] dd_x, dd_y, lim;
	map_pipe_t       first;

	function automatic map_pipe_t div_step(map_pipe_t p, logic [SCALE_W-1:0] s, int b);
		map_pipe_t     n;
		logic [RW-1:0] sub;
		n   = p;
		sub = RW'(s) << b;
		if (p.rem_x >= sub) begin
			n.rem_x  = p.rem_x - sub;
			n.q_x[b] = 1'b1;
		end
		if (p.rem_y >= sub) begin
			n.rem_y  = p.rem_y - sub;
			n.q_y[b] = 1'b1;
		end
		return n;
	endfunction

	always_comb begin
		adv_s2[QB] = !vld_s2[QB] || res_ready;
		for (int k = QB - 1; k >= 0; k--) begin
			adv_s2[k] = !vld_s2[k] || adv_s2[k+1];
		end
		adv_s1 = !v_s1 || adv_s2[0];
	end

	assign in_ready = adv_s1;

	always_comb begin
		dx = DW'(in_data.x_coord) - {cfg.h_off[OFS_W-1], cfg.h_off};
		dy = DW'(in_data.y_coord) - {cfg.v_off[OFS_W-1], cfg.v_off};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			item_s1   <= in_data;
			in_scr_s1 <= (DIM_W'(in_data.x_coord) < cfg.screen_w) &&
				(DIM_W'(in_data.y_coord) < cfg.screen_h);
			neg_x_s1  <= dx[DW-1];
			neg_y_s1  <= dy[DW-1];
			mag_x_s1  <= dx[DW-1] ? DW'(0) - dx : dx;
			mag_y_s1  <= dy[DW-1] ? DW'(0) - dy : dy;
		end
	end

	// quotient of 2^QB or more can never land inside the image
	always_comb begin
		dd_x         = {mag_x_s1, {SCALE_FRAC_BITS{1'b0}}};
		dd_y         = {mag_y_s1, {SCALE_FRAC_BITS{1'b0}}};
		lim          = DD_W'(cfg.scale) << QB;
		first.item   = item_s1;
		first.in_scr = in_scr_s1;
		first.neg_x  = neg_x_s1;
		first.neg_y  = neg_y_s1;
		first.ovf_x  = dd_x >= lim;
		first.ovf_y  = dd_y >= lim;
		first.rem_x  = dd_x[RW-1:0];
		first.rem_y  = dd_y[RW-1:0];
		first.q_x    = '0;
		first.q_y    = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2[0] <= 1'b0;
		end else if (adv_s2[0]) begin
			vld_s2[0] <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2[0] && v_s1) begin
			dp_s2[0] <= first;
		end
	end

	for (genvar k = 1; k <= QB; k++) begin : g_div
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s2[k] <= 1'b0;
			end else if (adv_s2[k]) begin
				vld_s2[k] <= vld_s2[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv_s2[k] && vld_s2[k-1]) begin
				dp_s2[k] <= div_step(dp_s2[k-1], cfg.scale, QB - k);
			end
		end
	end

	always_comb begin
		res_valid  = vld_s2[QB];
		res.item   = dp_s2[QB].item;
		res.in_scr = dp_s2[QB].in_scr;
		res.neg_x  = dp_s2[QB].neg_x;
		res.neg_y  = dp_s2[QB].neg_y;
		res.ovf_x  = dp_s2[QB].ovf_x;
		res.ovf_y  = dp_s2[QB].ovf_y;
		res.q_x    = dp_s2[QB].q_x;
		res.q_y    = dp_s2[QB].q_y;
	end

endmodule

/* hdl/lsp_fetch.sv */
// coverage test, store address, image store access and channel packing
module lsp_fetch #(
	parameter int unsigned MAX_PIXELS = lsp_pkg::DEF_MAX_IMAGE_PIXELS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  lsp_pkg::cfg_t     cfg,
	input  logic              in_valid,
	output logic              in_ready,
	input  lsp_pkg::map_res_t res,
	output logic              out_valid,
	input  logic              out_ready,
	output lsp_pkg::out_t     out_data
);
	import lsp_pkg::*;

	localparam int unsigned AW = $clog2(MAX_PIXELS);

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic adv_s1, adv_s2, adv_s3, adv_s4, adv_s5;

	logic             op_s1, cov_s1;
	logic [IDX_W-1:0] prod_s1;
	logic [DIM_W-1:0] add_s1;
	logic [RGB_W-1:0] rgb_s1;

	logic             op_s2, cov_s2, rng_s2;
	logic [IDX_W-1:0] idx_s2;
	logic [RGB_W-1:0] rgb_s2;

	logic             op_s3, cov_s3, rng_s3;
	logic [RGB_W-1:0] rd_s3;

	logic [RGB_W-1:0] mem [MAX_PIXELS];

	logic                  cov_s4;
	logic [2:0][PIX_W-1:0] ck_s4;
	logic [2:0][6:0]       sm_s4;

	out_t out_s5;

	logic             cov_a;
	logic [DIM_W-1:0] mul_a, add_a;
	logic [IDX_W-1:0] idx_b;
	logic [RGB_W-1:0] pix_d;
	logic [2:0][PIX_W-1:0] ck_d;
	logic [2:0][6:0]       sm_d;
	logic [PIX_W-1:0] val_e, mask_e;

	always_comb begin
		adv_s5   = !v_s5 || out_ready;
		adv_s4   = !v_s4 || adv_s5;
		adv_s3   = !v_s3 || adv_s4;
		adv_s2   = !v_s2 || adv_s3;
		adv_s1   = !v_s1 || adv_s2;
		in_ready = adv_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (adv_s1) v_s1 <= in_valid;
			if (adv_s2) v_s2 <= v_s1;
			if (adv_s3) v_s3 <= v_s2;
			// loads end at the store
			if (adv_s4) v_s4 <= v_s3 && op_s3 == OP_RENDER;
			if (adv_s5) v_s5 <= v_s4;
		end
	end

	// a negative distance maps to column zero only while the quotient is zero
	always_comb begin
		cov_a = res.item.operation == OP_RENDER && res.in_scr && !res.ovf_x && !res.ovf_y &&
			(!res.neg_x || res.q_x == '0) && (!res.neg_y || res.q_y == '0) &&
			res.q_x < cfg.image_w && res.q_y < cfg.image_h;
		mul_a = (res.item.operation == OP_RENDER) ? res.q_y : DIM_W'(res.item.y_coord);
		add_a = (res.item.operation == OP_RENDER) ? res.q_x : DIM_W'(res.item.x_coord);
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			op_s1   <= res.item.operation;
			cov_s1  <= cov_a;
			prod_s1 <= IDX_W'(mul_a) * IDX_W'(cfg.image_w);
			add_s1  <= add_a;
			rgb_s1  <= {res.item.red, res.item.green, res.item.blue};
		end
	end

	assign idx_b = prod_s1 + IDX_W'(add_s1);

	always_ff @(posedge clk) begin
		if (adv_s2 && v_s1) begin
			op_s2  <= op_s1;
			cov_s2 <= cov_s1;
			idx_s2 <= idx_b;
			rng_s2 <= idx_b < IDX_W'(MAX_PIXELS);
			rgb_s2 <= rgb_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s3 && v_s2) begin
			if (op_s2 == OP_LOAD && rng_s2) begin
				mem[idx_s2[AW-1:0]] <= rgb_s2;
			end
			rd_s3  <= mem[idx_s2[AW-1:0]];
			op_s3  <= op_s2;
			cov_s3 <= cov_s2;
			rng_s3 <= rng_s2;
		end
	end

	// c*(2^w-1)/255 split into c*k[w] and a small remainder term
	always_comb begin
		logic [CH_W-1:0]  c;
		logic [4:0]       w;
		logic [14:0]      t;
		logic [15:0]      u;
		pix_d = rng_s3 ? rd_s3 : '0;
		for (int i = 0; i < 3; i++) begin
			c       = pix_d[RGB_W-1-CH_W*i -: CH_W];
			w       = cfg.layout[GRP_W*i+5 +: 5];
			ck_d[i] = {{(PIX_W-CH_W){1'b0}}, c} * {{(PIX_W-SCALE_W){1'b0}}, CHAN_K[w]};
			t       = {7'b0, c} * ((15'd1 << w[2:0]) - 15'd1);
			u       = 16'(t) + 16'(t >> 8) + 16'd1;
			sm_d[i] = u[14:8];
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s4 && v_s3) begin
			cov_s4 <= cov_s3;
			ck_s4  <= ck_d;
			sm_s4  <= sm_d;
		end
	end

	always_comb begin
		logic [4:0] pos, w;
		val_e  = '0;
		mask_e = '0;
		for (int i = 0; i < 3; i++) begin
			pos    = cfg.layout[GRP_W*i +: 5];
			w      = cfg.layout[GRP_W*i+5 +: 5];
			val_e  = val_e | ((ck_s4[i] + PIX_W'(sm_s4[i])) << pos);
			mask_e = mask_e | (((PIX_W'(1) << w) - PIX_W'(1)) << pos);
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s5 && v_s4) begin
			out_s5.covered <= cov_s4;
			if (cov_s4) begin
				out_s5.pixel_value <= val_e;
			end else if (cfg.options[OPT_WHITE]) begin
				out_s5.pixel_value <= mask_e;
			end else begin
				out_s5.pixel_value <= '0;
			end
		end
	end

	assign out_valid = v_s5;
	assign out_data  = out_s5;

endmodule

/* hdl/letterbox_scaler_pixel_packer_core.sv */
// Nearest-neighbor letterbox scaler: loads fill the image store, renders return one packed
// display pixel each. Both item kinds share one in-order pipeline that takes an item every
// cycle unless back-pressure or a rebuild holds it; a render passes 15 stages of coordinate
// mapping (offset subtract, division setup, one per quotient bit of the scale division), then
// 5 stages of address, store read and channel packing; loads write the store at the same
// point where renders read it. After reset and every register write the fit scale and
// alignment offsets are rebuilt by a serial divider one bit per cycle, holding in_ready low.
module letterbox_scaler_pixel_packer_core #(
	parameter int unsigned MAX_IMAGE_PIXELS = lsp_pkg::DEF_MAX_IMAGE_PIXELS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [lsp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lsp_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  lsp_pkg::in_t                   in_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output lsp_pkg::out_t                  out_data
);
	import lsp_pkg::*;

	cfg_t     cfg;
	logic     map_in_ready;
	logic     map_valid, map_ready;
	map_res_t map_res;

	lsp_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cfg_wr_en),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	lsp_map u_map (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (in_valid && !cfg.busy),
		.in_ready  (map_in_ready),
		.in_data   (in_data),
		.res_valid (map_valid),
		.res_ready (map_ready),
		.res       (map_res)
	);

	lsp_fetch #(
		.MAX_PIXELS (MAX_IMAGE_PIXELS)
	) u_fetch (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (map_valid),
		.in_ready  (map_ready),
		.res       (map_res),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	assign in_ready = map_in_ready && !cfg.busy;

	a_cfg_rebuild: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr_en && cfg_index <= REG_LAYOUT |=> cfg.busy)
		else $error("register write did not start a rebuild of derived values");

	a_user_scale: assert property (@(posedge clk) disable iff (!arst_n)
		!cfg.busy && cfg.user_scale != '0 |-> cfg.scale == cfg.user_scale)
		else $error("effective scale differs from nonzero user scale");

	a_black_fill: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.covered && !cfg.options[OPT_WHITE] |->
		out_data.pixel_value == '0)
		else $error("background beat is not zero without white fill");

endmodule

/* tb/letterbox_scaler_pixel_packer_core_tb.sv */
// self-checking testbench for the letterbox scaler and pixel packer core
module letterbox_scaler_pixel_packer_core_tb;
	import lsp_pkg::*;

	localparam int STORE_DEPTH = DEF_MAX_IMAGE_PIXELS;
	localparam int SETTLE_CYCLES = 30;
	localparam int STALL_LIMIT = 3000;
	localparam int LONG_HOLD = 400;
	localparam logic [CFG_DATA_W-1:0] LAYOUT_RGB888 = 30'h11042100;
	localparam logic [CFG_DATA_W-1:0] LAYOUT_TOP = 30'h3FFFFFFF;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_t out_data;

	letterbox_scaler_pixel_packer_core uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// shadow of the block's registers and derived geometry
	longint scr_w, scr_h, img_w, img_h, usr_scale, opts, layout;
	longint eff_scale, h_off, v_off;
	bit [RGB_W-1:0] pix_mem [STORE_DEPTH];
	bit pix_written [STORE_DEPTH];
	out_t pixel_q [$];

	int errors = 0;
	bit no_idle = 1'b0;
	bit hold_out = 1'b0;

	function automatic longint fit_ratio(longint scr, longint img);
		longint q;
		if (img == 0) return longint'(SCALE_MAX);
		q = (scr << SCALE_FRAC_BITS) / img;
		return (q > longint'(SCALE_MAX)) ? longint'(SCALE_MAX) : q;
	endfunction

	function automatic longint align_ofs(longint scr, longint img, longint mode);
		longint scaled, diff;
		scaled = (img * eff_scale) >>> SCALE_FRAC_BITS;
		diff = scr - scaled;
		if (mode == longint'(ALIGN_NEAR)) return 0;
		if (mode == longint'(ALIGN_FAR)) return diff;
		return diff / 2;
	endfunction

	function automatic void rebuild_geometry();
		longint a, b;
		if (usr_scale != 0) begin
			eff_scale = usr_scale;
		end else begin
			a = fit_ratio(scr_w, img_w);
			b = fit_ratio(scr_h, img_h);
			eff_scale = (a < b) ? a : b;
		end
		h_off = align_ofs(scr_w, img_w, (opts >> 1) & 3);
		v_off = align_ofs(scr_h, img_h, (opts >> 3) & 3);
	endfunction

	function automatic void shadow_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
		case (idx)
			REG_SCREEN_W: scr_w = longint'(d & 30'h1FFF);
			REG_SCREEN_H: scr_h = longint'(d & 30'h1FFF);
			REG_IMAGE_W:  img_w = longint'(d & 30'h1FFF);
			REG_IMAGE_H:  img_h = longint'(d & 30'h1FFF);
			REG_SCALE:    usr_scale = longint'(d & 30'hFFFFFF);
			REG_OPTIONS:  opts = longint'(d & 30'h1F);
			REG_LAYOUT:   layout = longint'(d);
			default: return;
		endcase
		rebuild_geometry();
	endfunction

	function automatic bit [63:0] chan_level(bit [63:0] c, bit [GRP_W-1:0] g);
		bit [63:0] v;
		v = (c * ((64'd1 << g[9:5]) - 64'd1)) / 64'd255;
		return (v << g[4:0]) & 64'hFFFFFFFF;
	endfunction

	function automatic bit [63:0] chan_mask(bit [GRP_W-1:0] g);
		return (((64'd1 << g[9:5]) - 64'd1) << g[4:0]) & 64'hFFFFFFFF;
	endfunction

	// distance just left of the image still truncates to zero
	function automatic bit map_axis(longint p, longint off, longint lim, output longint q);
		longint d, mag;
		d = p - off;
		mag = (d < 0) ? -d : d;
		q = (mag << SCALE_FRAC_BITS) / eff_scale;
		if (d < 0 && q != 0) return 1'b0;
		return q < lim;
	endfunction

	// returns 1 when the render would read a store entry never loaded
	function automatic bit render_pixel(in_t it, output out_t r, output longint idx);
		longint sx, sy;
		bit cov;
		bit [63:0] pix;
		bit [RGB_W-1:0] p;
		bit [LAYOUT_W-1:0] lay;
		lay = layout[LAYOUT_W-1:0];
		cov = 1'b0;
		idx = -1;
		if (it.x_coord < scr_w && it.y_coord < scr_h && eff_scale != 0)
			if (map_axis(it.x_coord, h_off, img_w, sx) && map_axis(it.y_coord, v_off, img_h, sy))
				cov = 1'b1;
		if (cov) begin
			idx = sy * img_w + sx;
			p = (idx < STORE_DEPTH) ? pix_mem[idx] : '0;
			pix = chan_level(p[23:16], lay[9:0]) | chan_level(p[15:8], lay[19:10])
				| chan_level(p[7:0], lay[29:20]);
		end else if (opts & 1) begin
			pix = chan_mask(lay[9:0]) | chan_mask(lay[19:10]) | chan_mask(lay[29:20]);
		end else begin
			pix = '0;
		end
		r.pixel_value = pix[31:0];
		r.covered = cov;
		return cov && idx < STORE_DEPTH && !pix_written[idx];
	endfunction

	// update the shadow for a beat the block has taken
	task automatic commit_beat(in_t it, bit typed, out_t want);
		longint addr, idx;
		out_t r;
		if (it.operation == OP_LOAD) begin
			addr = longint'(it.y_coord) * img_w + it.x_coord;
			if (addr < STORE_DEPTH) begin
				pix_mem[addr] = {it.red, it.green, it.blue};
				pix_written[addr] = 1'b1;
			end
		end else begin
			void'(render_pixel(it, r, idx));
			pixel_q.push_back(typed ? want : r);
		end
	endtask

	task automatic send_beat(in_t it, bit typed = 1'b0, out_t want = '0);
		int gap;
		gap = no_idle ? 0 : int'($urandom_range(0, 13));
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_data <= it;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		commit_beat(it, typed, want);
	endtask

	// loads leave no result, so give the pipeline time to retire them too
	task automatic drain();
		in_valid <= 1'b0;
		wait (pixel_q.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic reg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
		cfg_index <= idx;
		cfg_data <= d;
		cfg_wr_en <= 1'b1;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
		shadow_write(idx, d);
	endtask

	function automatic in_t pick_beat(bit render);
		in_t it;
		int xl, yl;
		it.operation = render ? OP_RENDER : OP_LOAD;
		xl = int'(render ? scr_w + 3 : img_w - 1);
		yl = int'(render ? scr_h + 3 : img_h - 1);
		if (xl > 4095) xl = 4095;
		if (yl > 4095) yl = 4095;
		if (xl < 0) xl = 0;
		if (yl < 0) yl = 0;
		it.x_coord = ($urandom_range(0, 9) == 0) ? COORD_W'($urandom) : COORD_W'($urandom_range(0, xl));
		it.y_coord = ($urandom_range(0, 9) == 0) ? COORD_W'($urandom) : COORD_W'($urandom_range(0, yl));
		it.red = CH_W'($urandom);
		it.green = CH_W'($urandom);
		it.blue = CH_W'($urandom);
		return it;
	endfunction

	task automatic run_phase(longint sw, longint sh, longint iw, longint ih, longint sc,
			longint op, longint lay, int n, bit preload, bit hold, bit burst);
		in_t it;
		out_t r;
		longint idx;
		drain();
		reg_write(REG_SCREEN_W, CFG_DATA_W'(sw));
		reg_write(REG_SCREEN_H, CFG_DATA_W'(sh));
		reg_write(REG_IMAGE_W, CFG_DATA_W'(iw));
		reg_write(REG_IMAGE_H, CFG_DATA_W'(ih));
		reg_write(REG_SCALE, CFG_DATA_W'(sc));
		reg_write(REG_OPTIONS, CFG_DATA_W'(op));
		reg_write(REG_LAYOUT, CFG_DATA_W'(lay));
		no_idle = burst;
		if (preload)
			for (int y = 0; y < ih; y++)
				for (int x = 0; x < iw; x++) begin
					it = pick_beat(1'b0);
					it.x_coord = COORD_W'(x);
					it.y_coord = COORD_W'(y);
					send_beat(it);
				end
		hold_out = hold;
		for (int i = 0; i < n; i++) begin
			it = pick_beat($urandom_range(0, 9) < 7);
			if (it.operation == OP_RENDER && render_pixel(it, r, idx)) begin
				// fill the missing entry first so the render can come later
				if (idx % img_w > 4095 || idx / img_w > 4095) continue;
				it.operation = OP_LOAD;
				it.x_coord = COORD_W'(idx % img_w);
				it.y_coord = COORD_W'(idx / img_w);
			end
			send_beat(it);
		end
		no_idle = 1'b0;
	endtask

	typedef struct {
		bit is_reg;
		logic [CFG_IDX_W-1:0] idx;
		logic [CFG_DATA_W-1:0] d;
		in_t it;
		bit typed;
		out_t want;
	} plan_row_t;

	localparam out_t NO_PIX = '{32'h0, 1'b0};

	plan_row_t plan [] = '{
		'{0, REG_SCREEN_W, 0, '{OP_RENDER, 12'd4095, 12'd4095, 8'h5A, 8'hA5, 8'hFF}, 1, NO_PIX},
		'{1, REG_OPTIONS, 30'd1, '0, 0, NO_PIX},
		'{1, REG_LAYOUT, LAYOUT_RGB888, '0, 0, NO_PIX},
		'{0, REG_SCREEN_W, 0, '{OP_RENDER, 12'd4095, 12'd0, 8'h0, 8'h0, 8'h0}, 1,
			'{32'h00FFFFFF, 1'b0}},
		'{1, REG_LAYOUT, LAYOUT_TOP, '0, 0, NO_PIX},
		'{0, REG_SCREEN_W, 0, '{OP_RENDER, 12'd0, 12'd4095, 8'h0, 8'h0, 8'h0}, 1,
			'{32'h80000000, 1'b0}},
		'{1, REG_SCREEN_W, 30'd4, '0, 0, NO_PIX},
		'{1, REG_SCREEN_H, 30'd4, '0, 0, NO_PIX},
		'{1, REG_IMAGE_W, 30'd2, '0, 0, NO_PIX},
		'{1, REG_IMAGE_H, 30'd2, '0, 0, NO_PIX},
		'{1, REG_LAYOUT, LAYOUT_RGB888, '0, 0, NO_PIX},
		'{1, REG_OPTIONS, 30'd0, '0, 0, NO_PIX},
		'{0, REG_SCREEN_W, 0, '{OP_LOAD, 12'd0, 12'd0, 8'h00, 8'h00, 8'h00}, 0, NO_PIX},
		'{0, REG_SCREEN_W, 0, '{OP_LOAD, 12'd1, 12'd0, 8'hFF, 8'hFF, 8'hFF}, 0, NO_PIX},
		'{0, REG_SCREEN_W, 0, '{OP_LOAD, 12'd0, 12'd1, 8'hFF, 8'h00, 8'h80}, 0, NO_PIX},
		'{0, REG_SCREEN_W, 0, '{OP_LOAD, 12'd1, 12'd1, 8'h01, 8'h7F, 8'hFE}, 0, NO_PIX},
		'{0, REG_SCREEN_W, 0, '{OP_RENDER, 12'd0, 12'd0, 8'h0, 8'h0, 8'h0}, 0, NO_PIX},
		'{0, REG_SCREEN_W, 0, '{OP_RENDER, 12'd3, 12'd3, 8'h0, 8'h0, 8'h0}, 0, NO_PIX},
		'{0, REG_SCREEN_W, 0, '{OP_RENDER, 12'd1, 12'd2, 8'h0, 8'h0, 8'h0}, 0, NO_PIX},
		'{0, REG_SCREEN_W, 0, '{OP_RENDER, 12'd4, 12'd0, 8'h0, 8'h0, 8'h0}, 1, NO_PIX},
		'{1, REG_IMAGE_W, 30'd0, '0, 0, NO_PIX},
		'{0, REG_SCREEN_W, 0, '{OP_RENDER, 12'd1, 12'd1, 8'h0, 8'h0, 8'h0}, 0, NO_PIX},
		'{1, REG_IMAGE_W, 30'd2, '0, 0, NO_PIX},
		'{1, REG_SCALE, 30'hFFFFFF, '0, 0, NO_PIX},
		'{1, REG_OPTIONS, 30'd20, '0, 0, NO_PIX},
		'{0, REG_SCREEN_W, 0, '{OP_RENDER, 12'd3, 12'd3, 8'h0, 8'h0, 8'h0}, 0, NO_PIX},
		'{0, REG_SCREEN_W, 0, '{OP_RENDER, 12'd0, 12'd0, 8'h0, 8'h0, 8'h0}, 0, NO_PIX},
		'{1, REG_OPTIONS, 30'd31, '0, 0, NO_PIX},
		'{0, REG_SCREEN_W, 0, '{OP_RENDER, 12'd2, 12'd2, 8'h0, 8'h0, 8'h0}, 0, NO_PIX}
	};

	initial begin
		scr_w = 1920; scr_h = 1080; img_w = 256; img_h = 256;
		usr_scale = 0; opts = 0; layout = 0;
		rebuild_geometry();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (plan[i]) begin
			if (plan[i].is_reg) begin
				drain();
				reg_write(plan[i].idx, plan[i].d);
			end else begin
				send_beat(plan[i].it, plan[i].typed, plan[i].want);
			end
		end
		run_phase(40, 30, 8, 6, 0, $urandom_range(0, 31), $urandom & 30'h3FFFFFFF, 80, 1, 1, 0);
		run_phase(4096, 4096, 4096, 4096, 24'h10000, 0, LAYOUT_RGB888, 80, 0, 0, 0);
		run_phase(100, 1, 3, 1, 24'hFFFFFF, 21, LAYOUT_RGB888, 30, 1, 0, 1);
		run_phase(1, 1, 1, 1, 1, 30, $urandom & 30'h3FFFFFFF, 20, 1, 0, 0);
		run_phase(50, 50, 0, 5, 0, 1, LAYOUT_TOP, 20, 0, 0, 0);
		for (int p = 0; p < 4; p++)
			run_phase($urandom_range(1, 200), $urandom_range(1, 200), $urandom_range(1, 8),
				$urandom_range(1, 8), ($urandom_range(0, 1) ? 0 : $urandom_range(4096, 24'h80000)),
				$urandom_range(0, 31), $urandom & 30'h3FFFFFFF, 30, 1, 0, p[0]);
		drain();
		if (errors == 0)
			$display("letterbox_scaler_pixel_packer_core_tb passed");
		else
			$display("letterbox_scaler_pixel_packer_core_tb failed");
		$finish;
	end

	// result side: random back-pressure, one long hold-off on request
	initial begin
		int stall;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_out) begin
				hold_out = 1'b0;
				stall = LONG_HOLD;
			end else begin
				stall = no_idle ? 0 : int'($urandom_range(0, 13));
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pixel_q.size() == 0) begin
				$display("%0t unexpected beat pixel_value %h covered %b",
					$time, out_data.pixel_value, out_data.covered);
				errors++;
			end else begin
				want = pixel_q.pop_front();
				if (out_data.pixel_value !== want.pixel_value) begin
					$display("%0t pixel_value expected %h actual %h",
						$time, want.pixel_value, out_data.pixel_value);
					errors++;
				end
				if (out_data.covered !== want.covered) begin
					$display("%0t covered expected %b actual %b",
						$time, want.covered, out_data.covered);
					errors++;
				end
			end
		end
	end

	int quiet_cycles = 0;
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("letterbox_scaler_pixel_packer_core_tb failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

endmodule
